### design/ffa_pkg.sv
// Shared codes for the first-fit allocator: request functions and result status.
package ffa_pkg;

   typedef logic [2:0] status_type;

   localparam status_type STAT_OK           = 3'd0;
   localparam status_type STAT_OUT_OF_SPACE = 3'd1;
   localparam status_type STAT_OUTSIDE      = 3'd2;
   localparam status_type STAT_NOT_BLOCK    = 3'd3;
   localparam status_type STAT_ALREADY_FREE = 3'd4;

   localparam logic FUNC_ALLOC = 1'b0;
   localparam logic FUNC_FREE  = 1'b1;

   localparam int FIELD_W = 13;

endpackage

### design/ffa_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module ffa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

### design/first_fit_allocator.sv
// Allocate walks the blocks from the start of the arena; free releases a block and
// merges it with a free neighbour on either side.
// Throughput: one word at a time; the next word is taken once the previous result
// sits in the output register. The walk is set by one header memory read per block.
// Reset: synchronous; afterwards a clearing pass writes every header entry, one per
// cycle, during which no word is accepted.
module first_fit_allocator #(
   parameter int ARENA_BYTES = 4096,
   parameter int HDR_BYTES   = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic                        req_func,
   input  logic [ffa_pkg::FIELD_W-1:0] req_size,
   input  logic [ffa_pkg::FIELD_W-1:0] req_payload_addr,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output ffa_pkg::status_type         rsp_status,
   output logic [ffa_pkg::FIELD_W-1:0] rsp_addr,
   output logic [ffa_pkg::FIELD_W-1:0] rsp_allocated_bytes
);
   import ffa_pkg::*;

   localparam int AW = $clog2(ARENA_BYTES);
   localparam int SW = AW + 1;
   localparam int EW = SW + 2;
   localparam int CW = (AW + 2 > FIELD_W + 1) ? AW + 2 : FIELD_W + 1;
   localparam logic [CW-1:0] ARENA_C = CW'(ARENA_BYTES);
   localparam logic [CW-1:0] HDR_C   = CW'(HDR_BYTES);
   localparam logic [CW-1:0] INIT_C  = CW'(ARENA_BYTES - HDR_BYTES);
   localparam logic [AW-1:0] LAST_C  = AW'(ARENA_BYTES - 1);

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_A_RD, S_A_CHK, S_A_W2,
      S_F_CK0, S_F_HDR, S_F_PRV, S_F_NXT, S_F_W2, S_F_W3, S_RESP
   } state_type;

   function automatic logic [EW-1:0] pack_hdr(input logic mark, input logic fr,
                                              input logic [CW-1:0] size);
      return {mark, fr, size[SW-1:0]};
   endfunction

   state_type       state_ff;
   logic [AW-1:0]   clr_cnt_ff;
   logic [CW-1:0]   reqsz_ff, paddr_ff, off_ff, sz_ff, prsz_ff, nx_ff, n_ff, tsize_ff;
   logic [AW-1:0]   pr_ff, tgt_ff;
   logic            mprev_ff, mnext_ff;
   status_type      stat_ff;
   logic [FIELD_W-1:0] addr_ff, total_ff;
   logic            rsp_valid_ff;
   status_type      rsp_status_ff;
   logic [FIELD_W-1:0] rsp_addr_ff, rsp_bytes_ff;

   // Header memory: {mark, free, size}; link memory: offset of preceding block.
   logic            mem_we, pv_we;
   logic [AW-1:0]   mem_wa, mem_ra, pv_wa, pv_ra;
   logic [EW-1:0]   mem_wd, mem_rd;
   logic [AW-1:0]   pv_wd, pv_rd;

   logic            rd_mark, rd_free;
   logic [CW-1:0]   rd_size, a_next, a_n, a_nsz, ptr, base_sz, tsz, f_nxt;
   logic            a_fit, a_whole, mnext_now;
   logic [AW-1:0]   tgt_now;

   ffa_ram #(.WIDTH(EW), .DEPTH(ARENA_BYTES)) u_hdr_ram (
      .clock(clock), .wr_en(mem_we), .wr_addr(mem_wa), .wr_data(mem_wd),
      .rd_addr(mem_ra), .rd_data(mem_rd)
   );

   ffa_ram #(.WIDTH(AW), .DEPTH(ARENA_BYTES)) u_prev_ram (
      .clock(clock), .wr_en(pv_we), .wr_addr(pv_wa), .wr_data(pv_wd),
      .rd_addr(pv_ra), .rd_data(pv_rd)
   );

   always_comb begin
      rd_mark   = mem_rd[EW-1];
      rd_free   = mem_rd[EW-2];
      rd_size   = {{(CW-SW){1'b0}}, mem_rd[SW-1:0]};
      a_next    = off_ff + HDR_C + rd_size;
      a_fit     = rd_free && (rd_size >= reqsz_ff);
      a_whole   = rd_size < (reqsz_ff + HDR_C);
      a_n       = off_ff + HDR_C + reqsz_ff;
      a_nsz     = rd_size - HDR_C - reqsz_ff;
      ptr       = paddr_ff - HDR_C;
      mnext_now = (nx_ff < ARENA_C) && rd_mark && rd_free;
      base_sz   = mprev_ff ? (prsz_ff + HDR_C + sz_ff) : sz_ff;
      tsz       = base_sz + (mnext_now ? (HDR_C + rd_size) : '0);
      tgt_now   = mprev_ff ? pr_ff : ptr[AW-1:0];
      f_nxt     = {{(CW-AW){1'b0}}, tgt_ff} + HDR_C + tsize_ff;
   end

   always_comb begin
      mem_we = 1'b0;
      mem_wa = '0;
      mem_wd = '0;
      mem_ra = '0;
      pv_we  = 1'b0;
      pv_wa  = '0;
      pv_wd  = '0;
      pv_ra  = '0;
      case (state_ff)
         S_CLEAR: begin
            mem_we = 1'b1;
            mem_wa = clr_cnt_ff;
            mem_wd = (clr_cnt_ff == '0) ? pack_hdr(1'b1, 1'b1, INIT_C) : '0;
         end
         S_A_RD: begin
            mem_ra = off_ff[AW-1:0];
         end
         S_A_CHK: begin
            if (rd_mark && a_fit) begin
               mem_we = 1'b1;
               if (a_whole) begin
                  mem_wa = off_ff[AW-1:0];
                  mem_wd = pack_hdr(1'b1, 1'b0, rd_size);
               end else begin
                  // Split: the remainder becomes a free block of its own.
                  mem_wa = a_n[AW-1:0];
                  mem_wd = pack_hdr(1'b1, 1'b1, a_nsz);
                  pv_we  = 1'b1;
                  pv_wa  = a_n[AW-1:0];
                  pv_wd  = off_ff[AW-1:0];
               end
            end
         end
         S_A_W2: begin
            mem_we = 1'b1;
            mem_wa = off_ff[AW-1:0];
            mem_wd = pack_hdr(1'b1, 1'b0, reqsz_ff);
            pv_we  = nx_ff < ARENA_C;
            pv_wa  = nx_ff[AW-1:0];
            pv_wd  = n_ff[AW-1:0];
         end
         S_F_CK0: begin
            mem_ra = ptr[AW-1:0];
            pv_ra  = ptr[AW-1:0];
         end
         S_F_HDR: begin
            mem_ra = (ptr != '0) ? pv_rd : '0;
         end
         S_F_PRV: begin
            mem_ra = (nx_ff < ARENA_C) ? nx_ff[AW-1:0] : '0;
         end
         S_F_NXT: begin
            mem_we = 1'b1;
            mem_wa = tgt_now;
            mem_wd = pack_hdr(1'b1, 1'b1, tsz);
         end
         S_F_W2: begin
            mem_we = mprev_ff;
            mem_wa = ptr[AW-1:0];
            pv_we  = f_nxt < ARENA_C;
            pv_wa  = f_nxt[AW-1:0];
            pv_wd  = tgt_ff;
         end
         S_F_W3: begin
            mem_we = mnext_ff;
            mem_wa = nx_ff[AW-1:0];
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_cnt_ff   <= '0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_ready && state_ff != S_RESP) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_CLEAR: begin
               clr_cnt_ff <= clr_cnt_ff + 1'b1;
               if (clr_cnt_ff == LAST_C) begin
                  state_ff <= S_IDLE;
               end
            end
            S_IDLE: begin
               if (req_valid) begin
                  reqsz_ff <= CW'(req_size);
                  paddr_ff <= CW'(req_payload_addr);
                  off_ff   <= '0;
                  addr_ff  <= '0;
                  stat_ff  <= STAT_OK;
                  state_ff <= (req_func == FUNC_FREE) ? S_F_CK0 : S_A_RD;
               end
            end
            S_A_RD: begin
               if (off_ff >= ARENA_C) begin
                  stat_ff  <= STAT_OUT_OF_SPACE;
                  state_ff <= S_RESP;
               end else begin
                  state_ff <= S_A_CHK;
               end
            end
            S_A_CHK: begin
               if (!rd_mark) begin
                  stat_ff  <= STAT_OUT_OF_SPACE;
                  state_ff <= S_RESP;
               end else if (a_fit) begin
                  addr_ff <= FIELD_W'(off_ff + HDR_C);
                  if (a_whole) begin
                     total_ff <= total_ff + FIELD_W'(rd_size);
                     state_ff <= S_RESP;
                  end else begin
                     total_ff <= total_ff + FIELD_W'(reqsz_ff);
                     n_ff     <= a_n;
                     nx_ff    <= a_next;
                     state_ff <= S_A_W2;
                  end
               end else begin
                  off_ff   <= a_next;
                  state_ff <= S_A_RD;
               end
            end
            S_A_W2: begin
               state_ff <= S_RESP;
            end
            S_F_CK0: begin
               if (paddr_ff > ARENA_C) begin
                  stat_ff  <= STAT_OUTSIDE;
                  state_ff <= S_RESP;
               end else if (paddr_ff < HDR_C) begin
                  stat_ff  <= STAT_NOT_BLOCK;
                  state_ff <= S_RESP;
               end else begin
                  state_ff <= S_F_HDR;
               end
            end
            S_F_HDR: begin
               if (!rd_mark) begin
                  stat_ff  <= STAT_NOT_BLOCK;
                  state_ff <= S_RESP;
               end else if (rd_free) begin
                  stat_ff  <= STAT_ALREADY_FREE;
                  state_ff <= S_RESP;
               end else begin
                  sz_ff    <= rd_size;
                  total_ff <= total_ff - FIELD_W'(rd_size);
                  nx_ff    <= paddr_ff + rd_size;
                  pr_ff    <= pv_rd;
                  state_ff <= S_F_PRV;
               end
            end
            S_F_PRV: begin
               mprev_ff <= (ptr != '0) && rd_mark && rd_free;
               prsz_ff  <= rd_size;
               state_ff <= S_F_NXT;
            end
            S_F_NXT: begin
               mnext_ff <= mnext_now;
               tgt_ff   <= tgt_now;
               tsize_ff <= tsz;
               state_ff <= S_F_W2;
            end
            S_F_W2: begin
               state_ff <= S_F_W3;
            end
            S_F_W3: begin
               state_ff <= S_RESP;
            end
            S_RESP: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_status_ff <= stat_ff;
                  rsp_addr_ff   <= addr_ff;
                  rsp_bytes_ff  <= total_ff;
                  state_ff      <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign req_ready           = (state_ff == S_IDLE);
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = rsp_status_ff;
   assign rsp_addr            = rsp_addr_ff;
   assign rsp_allocated_bytes = rsp_bytes_ff;

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("word accepted while another is in progress");

   a_fail_no_addr: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != STAT_OK |-> rsp_addr == '0)
      else $error("failed request carries a nonzero address");

   a_clear_blocks: assert property (@(posedge clock)
      reset |=> !req_ready)
      else $error("word accepted before the clearing pass");

   a_alloc_addr_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STAT_OK && rsp_addr != '0 |->
         rsp_addr >= FIELD_W'(HDR_BYTES))
      else $error("allocated address lies inside the first header");

endmodule
